// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the drive state machine unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SDSM_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sdsm assertion failed");

// next-cycle implication, checked out of reset
`define SDSM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sdsm assertion failed");

`endif

// ===== hw/rtl/sdsm_pkg.sv =====
package sdsm_pkg;

    // drive states, same encoding as the state fields
    localparam logic [3:0] ST_ERROR = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_NRDY  = 4'd2;
    localparam logic [3:0] ST_SOD   = 4'd3;
    localparam logic [3:0] ST_RDY   = 4'd4;
    localparam logic [3:0] ST_SON   = 4'd5;
    localparam logic [3:0] ST_OPE   = 4'd6;
    localparam logic [3:0] ST_QSA   = 4'd7;
    localparam logic [3:0] ST_FRA   = 4'd8;
    localparam logic [3:0] ST_FLT   = 4'd9;

    localparam logic [2:0] CMD_SHUTDOWN  = 3'd0;
    localparam logic [2:0] CMD_SWITCH_ON = 3'd1;
    localparam logic [2:0] CMD_ENABLE    = 3'd2;
    localparam logic [2:0] CMD_DISABLE_V = 3'd3;
    localparam logic [2:0] CMD_QSTOP     = 3'd4;
    localparam logic [2:0] CMD_FRESET    = 3'd5;
    localparam logic [2:0] CMD_HALT      = 3'd6;

    localparam logic [1:0] WARN_NONE        = 2'd0;
    localparam logic [1:0] WARN_UNSUPPORTED = 2'd1;
    localparam logic [1:0] WARN_SAFETY      = 2'd2;
    localparam logic [1:0] WARN_SENSORS     = 2'd3;

    localparam logic ACT_CONTROL = 1'b0;
    localparam logic ACT_FORCE   = 1'b1;

    localparam logic [15:0] MASK_A = 16'h004F;
    localparam logic [15:0] MASK_B = 16'h006F;

    typedef struct packed {
        logic        action;
        logic [15:0] control_word;
        logic [3:0]  forced_state;
        logic        safety_ok;
        logic        sensors_config_active;
        logic        unrecoverable_fault;
        logic        clutch_manual_flag;
    } sdsm_in_t;

    typedef struct packed {
        logic [15:0] status_word;
        logic [3:0]  power_state;
        logic        state_changed;
        logic [2:0]  command_code;
        logic [1:0]  warning_code;
        logic        clear_power_ready;
        logic        clear_clutch_manual;
        logic        reset_filters_pulse;
        logic        init_mode_pulse;
    } sdsm_out_t;

    function automatic logic [3:0] decode_state(logic [15:0] sw);
        logic [15:0] a;
        logic [15:0] b;
        logic [3:0]  st;
        a = sw & MASK_A;
        b = sw & MASK_B;
        priority if (a == 16'h0000) st = ST_NRDY;
        else if (a == 16'h0040) st = ST_SOD;
        else if (a == 16'h000F) st = ST_FRA;
        else if (a == 16'h0008) st = ST_FLT;
        else if (b == 16'h0021) st = ST_RDY;
        else if (b == 16'h0023) st = ST_SON;
        else if (b == 16'h0027) st = ST_OPE;
        else if (b == 16'h0007) st = ST_QSA;
        else st = ST_ERROR;
        return st;
    endfunction

    function automatic logic [2:0] decode_command(logic [15:0] cw);
        logic [2:0] cmd;
        priority if (cw[7]) cmd = CMD_FRESET;
        else if (!cw[1]) cmd = CMD_DISABLE_V;
        else if (!cw[2]) cmd = CMD_QSTOP;
        else if (!cw[0]) cmd = CMD_SHUTDOWN;
        else if (cw[3]) cmd = cw[8] ? CMD_HALT : CMD_ENABLE;
        else cmd = CMD_SWITCH_ON;
        return cmd;
    endfunction

    // status word after writing a state; unwritable states leave it alone
    function automatic logic [15:0] write_state(logic [15:0] sw, logic [3:0] st);
        logic [15:0] r;
        unique case (st)
            ST_NRDY: r = (sw & ~MASK_A) | 16'h0000;
            ST_SOD:  r = (sw & ~MASK_A) | 16'h0040;
            ST_RDY:  r = (sw & ~MASK_B) | 16'h0021;
            ST_SON:  r = (sw & ~MASK_B) | 16'h0023;
            ST_OPE:  r = (sw & ~MASK_B) | 16'h0027;
            ST_QSA:  r = (sw & ~MASK_B) | 16'h0007;
            ST_FRA:  r = (sw & ~MASK_A) | 16'h000F;
            ST_FLT:  r = (sw & ~MASK_A) | 16'h0008;
            default: r = sw;
        endcase
        return r;
    endfunction

    function automatic logic writable(logic [3:0] st);
        return (st >= ST_NRDY) && (st <= ST_FLT);
    endfunction

endpackage

// ===== hw/rtl/servo_drive_state_machine_unit.sv =====
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    item   (sdsm_in_t)
// result    out        result_valid / result_stall result (sdsm_out_t)
//
// one item per cycle unless the result stalls; an item is held in in_reg, then out_reg
// the status register is read and written in the single decode pass between the
// input register and the result register, so consecutive items chain without gaps
// reset clears the status bits (not ready to switch on) and both valid flags
// a stalled result holds; the input register keeps taking items while the result moves
`include "assert_macros.svh"

module servo_drive_state_machine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sdsm_pkg::sdsm_in_t item,
    output logic               result_valid,
    input  logic               result_stall,
    output sdsm_pkg::sdsm_out_t result
);

    logic                in_v_reg;
    sdsm_pkg::sdsm_in_t  in_reg;
    logic                out_v_reg;
    sdsm_pkg::sdsm_out_t out_reg;
    logic [15:0]         status_reg;

    logic                out_free;
    logic                move;
    logic                take;
    logic [15:0]         status_next;
    sdsm_pkg::sdsm_out_t out_next;

    logic [3:0]          cur_st;
    logic [3:0]          target;
    logic [2:0]          cmd;
    logic [1:0]          warn;
    logic                drop_power;
    logic                drop_clutch;
    logic                reinit_mode;

    assign out_free     = !out_v_reg || !result_stall;
    assign move         = in_v_reg && out_free;
    assign item_stall   = in_v_reg && !out_free;
    assign take         = item_valid && !item_stall;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    always_comb
    begin
        cur_st      = sdsm_pkg::decode_state(status_reg);
        cmd         = sdsm_pkg::decode_command(in_reg.control_word);
        target      = sdsm_pkg::ST_ERROR;
        warn        = sdsm_pkg::WARN_NONE;
        drop_power  = 1'b0;
        drop_clutch = 1'b0;
        reinit_mode = 1'b0;

        unique case (cmd)
            sdsm_pkg::CMD_SHUTDOWN:
            begin
                priority if (cur_st == sdsm_pkg::ST_SOD || cur_st == sdsm_pkg::ST_SON)
                    target = sdsm_pkg::ST_RDY;
                else if (cur_st == sdsm_pkg::ST_OPE)
                begin
                    target      = sdsm_pkg::ST_RDY;
                    drop_power  = 1'b1;
                    drop_clutch = 1'b1;
                end
                else if (cur_st == sdsm_pkg::ST_FRA)
                    drop_power = 1'b1;
                else if (cur_st != sdsm_pkg::ST_RDY)
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
                else
                    warn = sdsm_pkg::WARN_NONE;
            end
            sdsm_pkg::CMD_SWITCH_ON:
            begin
                priority if (cur_st == sdsm_pkg::ST_RDY)
                    target = sdsm_pkg::ST_SON;
                else if (cur_st == sdsm_pkg::ST_OPE)
                begin
                    target      = sdsm_pkg::ST_SON;
                    drop_power  = 1'b1;
                    drop_clutch = 1'b1;
                end
                else if (cur_st == sdsm_pkg::ST_FRA)
                begin
                    drop_power  = 1'b1;
                    drop_clutch = 1'b1;
                end
                else if (cur_st != sdsm_pkg::ST_SON)
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
                else
                    warn = sdsm_pkg::WARN_NONE;
            end
            sdsm_pkg::CMD_ENABLE:
            begin
                // sensor check comes before the safety check
                priority if (cur_st == sdsm_pkg::ST_SON)
                begin
                    priority if (!in_reg.sensors_config_active)
                        warn = sdsm_pkg::WARN_SENSORS;
                    else if (!in_reg.safety_ok)
                        warn = sdsm_pkg::WARN_SAFETY;
                    else
                        target = sdsm_pkg::ST_OPE;
                end
                else if (cur_st != sdsm_pkg::ST_OPE)
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
                else
                    warn = sdsm_pkg::WARN_NONE;
            end
            sdsm_pkg::CMD_DISABLE_V:
            begin
                priority if (cur_st == sdsm_pkg::ST_RDY || cur_st == sdsm_pkg::ST_SON)
                    target = sdsm_pkg::ST_SOD;
                else if (cur_st == sdsm_pkg::ST_OPE || cur_st == sdsm_pkg::ST_QSA)
                begin
                    target      = sdsm_pkg::ST_SOD;
                    drop_power  = 1'b1;
                    drop_clutch = 1'b1;
                end
                else if (cur_st == sdsm_pkg::ST_FRA)
                begin
                    drop_power  = 1'b1;
                    drop_clutch = 1'b1;
                end
                else if (cur_st != sdsm_pkg::ST_SOD)
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
                else
                    warn = sdsm_pkg::WARN_NONE;
            end
            sdsm_pkg::CMD_QSTOP:
            begin
                priority if (cur_st == sdsm_pkg::ST_RDY || cur_st == sdsm_pkg::ST_SON)
                    target = sdsm_pkg::ST_SOD;
                else if (cur_st == sdsm_pkg::ST_OPE)
                    target = sdsm_pkg::ST_QSA;
                else if (cur_st != sdsm_pkg::ST_QSA && cur_st != sdsm_pkg::ST_SOD)
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
                else
                    warn = sdsm_pkg::WARN_NONE;
            end
            sdsm_pkg::CMD_FRESET:
            begin
                // an unrecoverable fault blocks the reset silently
                priority if (cur_st == sdsm_pkg::ST_FLT)
                begin
                    if (!in_reg.unrecoverable_fault)
                        target = sdsm_pkg::ST_SOD;
                end
                else
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
            end
            default:
            begin
                // halt
                if (cur_st == sdsm_pkg::ST_OPE)
                    reinit_mode = 1'b1;
                else
                    warn = sdsm_pkg::WARN_UNSUPPORTED;
            end
        endcase

        out_next = '0;
        if (in_reg.action == sdsm_pkg::ACT_FORCE)
        begin
            status_next            = sdsm_pkg::write_state(status_reg, in_reg.forced_state);
            out_next.state_changed = sdsm_pkg::writable(in_reg.forced_state);
        end
        else
        begin
            status_next                  = sdsm_pkg::write_state(status_reg, target);
            out_next.state_changed       = sdsm_pkg::writable(target);
            out_next.command_code        = cmd;
            out_next.warning_code        = warn;
            out_next.clear_power_ready   = drop_power;
            out_next.clear_clutch_manual = drop_clutch;
            out_next.reset_filters_pulse = drop_clutch && in_reg.clutch_manual_flag;
            out_next.init_mode_pulse     = reinit_mode;
        end
        out_next.status_word = status_next;
        out_next.power_state = sdsm_pkg::decode_state(status_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            status_reg <= '0;
        end
        else
        begin
            if (take)
                in_v_reg <= 1'b1;
            else if (move)
                in_v_reg <= 1'b0;

            if (move)
            begin
                out_v_reg  <= 1'b1;
                status_reg <= status_next;
            end
            else if (!result_stall)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= item;
        if (move)
            out_reg <= out_next;
    end

    // while a result is valid, the status register matches its status word
    `SDSM_ASSERT_NOW(a_status_tracks, clk, rst_n, out_v_reg, status_reg == out_reg.status_word)
    `SDSM_ASSERT_NEXT(a_move_fills, clk, rst_n, move, out_v_reg)
    `SDSM_ASSERT_NOW(a_warn_no_write, clk, rst_n,
        out_v_reg && out_reg.warning_code != sdsm_pkg::WARN_NONE, !out_reg.state_changed)
    `SDSM_ASSERT_NOW(a_halt_in_op, clk, rst_n, out_v_reg && out_reg.init_mode_pulse,
        out_reg.power_state == sdsm_pkg::ST_OPE && !out_reg.state_changed)

endmodule

// ===== bench/servo_drive_state_machine_unit_tb.sv =====
`timescale 1ns / 100ps

module servo_drive_state_machine_unit_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;

    // status bit patterns of each state, under MASK_A or MASK_B
    localparam logic [15:0] PAT_NRDY = 16'h0000;
    localparam logic [15:0] PAT_SOD  = 16'h0040;
    localparam logic [15:0] PAT_FRA  = 16'h000F;
    localparam logic [15:0] PAT_FLT  = 16'h0008;
    localparam logic [15:0] PAT_RDY  = 16'h0021;
    localparam logic [15:0] PAT_SON  = 16'h0023;
    localparam logic [15:0] PAT_OPE  = 16'h0027;
    localparam logic [15:0] PAT_QSA  = 16'h0007;

    // state codes with no meaning
    localparam logic [3:0] ST_UNUSED_LOW = 4'd10;
    localparam logic [3:0] ST_UNUSED_TOP = 4'd15;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    sdsm_pkg::sdsm_in_t   item_in = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    sdsm_pkg::sdsm_out_t  result_out;

    sdsm_pkg::sdsm_in_t   pending_items[$];
    sdsm_pkg::sdsm_out_t  expected_results[$];
    logic [15:0]          model_status = '0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    servo_drive_state_machine_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [3:0] state_of(logic [15:0] sw);
        logic [3:0] st;
        st = sdsm_pkg::ST_ERROR;
        case (sw & sdsm_pkg::MASK_A)
            PAT_NRDY: st = sdsm_pkg::ST_NRDY;
            PAT_SOD:  st = sdsm_pkg::ST_SOD;
            PAT_FRA:  st = sdsm_pkg::ST_FRA;
            PAT_FLT:  st = sdsm_pkg::ST_FLT;
            default:
            begin
                case (sw & sdsm_pkg::MASK_B)
                    PAT_RDY: st = sdsm_pkg::ST_RDY;
                    PAT_SON: st = sdsm_pkg::ST_SON;
                    PAT_OPE: st = sdsm_pkg::ST_OPE;
                    PAT_QSA: st = sdsm_pkg::ST_QSA;
                    default: st = sdsm_pkg::ST_ERROR;
                endcase
            end
        endcase
        return st;
    endfunction

    // msb set when the state bits were written
    function automatic logic [16:0] place_state(logic [15:0] sw, logic [3:0] st);
        logic [15:0] mask;
        logic [15:0] pattern;
        logic        ok;
        ok = 1'b1;
        mask = sdsm_pkg::MASK_B;
        pattern = '0;
        case (st)
            sdsm_pkg::ST_NRDY: begin mask = sdsm_pkg::MASK_A; pattern = PAT_NRDY; end
            sdsm_pkg::ST_SOD:  begin mask = sdsm_pkg::MASK_A; pattern = PAT_SOD;  end
            sdsm_pkg::ST_FRA:  begin mask = sdsm_pkg::MASK_A; pattern = PAT_FRA;  end
            sdsm_pkg::ST_FLT:  begin mask = sdsm_pkg::MASK_A; pattern = PAT_FLT;  end
            sdsm_pkg::ST_RDY:  pattern = PAT_RDY;
            sdsm_pkg::ST_SON:  pattern = PAT_SON;
            sdsm_pkg::ST_OPE:  pattern = PAT_OPE;
            sdsm_pkg::ST_QSA:  pattern = PAT_QSA;
            default: ok = 1'b0;
        endcase
        return ok ? {1'b1, (sw & ~mask) | pattern} : {1'b0, sw};
    endfunction

    function automatic logic [2:0] command_of(logic [15:0] cw);
        logic [2:0] cmd;
        // halt, fault reset, enable op, quick stop, enable voltage, switch on
        casez ({cw[8], cw[7], cw[3], cw[2], cw[1], cw[0]})
            6'b?1????: cmd = sdsm_pkg::CMD_FRESET;
            6'b?0??0?: cmd = sdsm_pkg::CMD_DISABLE_V;
            6'b?0?01?: cmd = sdsm_pkg::CMD_QSTOP;
            6'b?0?110: cmd = sdsm_pkg::CMD_SHUTDOWN;
            6'b101111: cmd = sdsm_pkg::CMD_HALT;
            6'b001111: cmd = sdsm_pkg::CMD_ENABLE;
            default:   cmd = sdsm_pkg::CMD_SWITCH_ON;
        endcase
        return cmd;
    endfunction

    function automatic sdsm_pkg::sdsm_out_t predict_drive(sdsm_pkg::sdsm_in_t it);
        sdsm_pkg::sdsm_out_t r;
        logic [3:0]  now_st;
        logic [3:0]  goal;
        logic [16:0] placed;
        logic        drop_power;
        logic        drop_clutch;
        r = '0;
        if (it.action == sdsm_pkg::ACT_FORCE)
        begin
            placed = place_state(model_status, it.forced_state);
        end
        else
        begin
            now_st = state_of(model_status);
            goal = sdsm_pkg::ST_ERROR;
            drop_power = 1'b0;
            drop_clutch = 1'b0;
            r.command_code = command_of(it.control_word);
            r.warning_code = sdsm_pkg::WARN_NONE;
            case (r.command_code)
                sdsm_pkg::CMD_SHUTDOWN:
                begin
                    if (now_st == sdsm_pkg::ST_SOD || now_st == sdsm_pkg::ST_SON)
                        goal = sdsm_pkg::ST_RDY;
                    else if (now_st == sdsm_pkg::ST_OPE)
                    begin
                        goal = sdsm_pkg::ST_RDY;
                        drop_power = 1'b1;
                        drop_clutch = 1'b1;
                    end
                    else if (now_st == sdsm_pkg::ST_FRA)
                        drop_power = 1'b1;
                    else if (now_st != sdsm_pkg::ST_RDY)
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                sdsm_pkg::CMD_SWITCH_ON:
                begin
                    if (now_st == sdsm_pkg::ST_RDY)
                        goal = sdsm_pkg::ST_SON;
                    else if (now_st == sdsm_pkg::ST_OPE)
                    begin
                        goal = sdsm_pkg::ST_SON;
                        drop_power = 1'b1;
                        drop_clutch = 1'b1;
                    end
                    else if (now_st == sdsm_pkg::ST_FRA)
                    begin
                        drop_power = 1'b1;
                        drop_clutch = 1'b1;
                    end
                    else if (now_st != sdsm_pkg::ST_SON)
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                sdsm_pkg::CMD_ENABLE:
                begin
                    if (now_st == sdsm_pkg::ST_SON)
                    begin
                        if (!it.sensors_config_active)
                            r.warning_code = sdsm_pkg::WARN_SENSORS;
                        else if (!it.safety_ok)
                            r.warning_code = sdsm_pkg::WARN_SAFETY;
                        else
                            goal = sdsm_pkg::ST_OPE;
                    end
                    else if (now_st != sdsm_pkg::ST_OPE)
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                sdsm_pkg::CMD_DISABLE_V:
                begin
                    if (now_st == sdsm_pkg::ST_RDY || now_st == sdsm_pkg::ST_SON)
                        goal = sdsm_pkg::ST_SOD;
                    else if (now_st == sdsm_pkg::ST_OPE || now_st == sdsm_pkg::ST_QSA)
                    begin
                        goal = sdsm_pkg::ST_SOD;
                        drop_power = 1'b1;
                        drop_clutch = 1'b1;
                    end
                    else if (now_st == sdsm_pkg::ST_FRA)
                    begin
                        drop_power = 1'b1;
                        drop_clutch = 1'b1;
                    end
                    else if (now_st != sdsm_pkg::ST_SOD)
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                sdsm_pkg::CMD_QSTOP:
                begin
                    if (now_st == sdsm_pkg::ST_RDY || now_st == sdsm_pkg::ST_SON)
                        goal = sdsm_pkg::ST_SOD;
                    else if (now_st == sdsm_pkg::ST_OPE)
                        goal = sdsm_pkg::ST_QSA;
                    else if (now_st != sdsm_pkg::ST_QSA && now_st != sdsm_pkg::ST_SOD)
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                sdsm_pkg::CMD_FRESET:
                begin
                    // an unrecoverable fault blocks the reset silently
                    if (now_st == sdsm_pkg::ST_FLT)
                    begin
                        if (!it.unrecoverable_fault)
                            goal = sdsm_pkg::ST_SOD;
                    end
                    else
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
                default:
                begin
                    if (now_st == sdsm_pkg::ST_OPE)
                        r.init_mode_pulse = 1'b1;
                    else
                        r.warning_code = sdsm_pkg::WARN_UNSUPPORTED;
                end
            endcase
            r.clear_power_ready = drop_power;
            r.clear_clutch_manual = drop_clutch;
            r.reset_filters_pulse = drop_clutch & it.clutch_manual_flag;
            placed = place_state(model_status, goal);
        end
        model_status = placed[15:0];
        r.state_changed = placed[16];
        r.status_word = model_status;
        r.power_state = state_of(model_status);
        return r;
    endfunction

    // random control word that decodes to the given command
    function automatic logic [15:0] cw_for(logic [2:0] cmd);
        logic [15:0] cw;
        cw = 16'($urandom);
        if (cmd == sdsm_pkg::CMD_FRESET)
            cw[7] = 1'b1;
        else
        begin
            cw[7] = 1'b0;
            cw[1] = (cmd != sdsm_pkg::CMD_DISABLE_V);
            if (cmd != sdsm_pkg::CMD_DISABLE_V)
            begin
                cw[2] = (cmd != sdsm_pkg::CMD_QSTOP);
                if (cmd != sdsm_pkg::CMD_QSTOP)
                begin
                    cw[0] = (cmd != sdsm_pkg::CMD_SHUTDOWN);
                    if (cmd != sdsm_pkg::CMD_SHUTDOWN)
                    begin
                        cw[3] = (cmd != sdsm_pkg::CMD_SWITCH_ON);
                        if (cmd != sdsm_pkg::CMD_SWITCH_ON)
                            cw[8] = (cmd == sdsm_pkg::CMD_HALT);
                    end
                end
            end
        end
        return cw;
    endfunction

    function automatic sdsm_pkg::sdsm_in_t make_control(logic [2:0] cmd, logic safety,
                                                        logic sensors, logic unrec);
        sdsm_pkg::sdsm_in_t it;
        it.action = sdsm_pkg::ACT_CONTROL;
        it.control_word = cw_for(cmd);
        it.forced_state = 4'($urandom);
        it.safety_ok = safety;
        it.sensors_config_active = sensors;
        it.unrecoverable_fault = unrec;
        it.clutch_manual_flag = 1'($urandom);
        return it;
    endfunction

    function automatic sdsm_pkg::sdsm_in_t make_force(logic [3:0] st);
        sdsm_pkg::sdsm_in_t it;
        it = make_control(3'($urandom_range(0, 6)), 1'($urandom), 1'($urandom), 1'($urandom));
        it.action = sdsm_pkg::ACT_FORCE;
        it.forced_state = st;
        return it;
    endfunction

    function automatic logic likely();
        return $urandom_range(0, 99) < 85;
    endfunction

    task automatic queue_random(int count);
        sdsm_pkg::sdsm_in_t it;
        int       n;
        int       pick;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                pending_items.push_back(make_force(4'($urandom)));
                n++;
            end
            else if (pick < 14)
            begin
                // noise: every field random but the action
                it = make_control(sdsm_pkg::CMD_SHUTDOWN, 1'($urandom), 1'($urandom),
                                  1'($urandom));
                it.control_word = 16'($urandom);
                pending_items.push_back(it);
                n++;
            end
            else if (pick < 30)
            begin
                // power-up path, fault reset first in case we sit in fault
                pending_items.push_back(make_control(sdsm_pkg::CMD_FRESET, 1'($urandom),
                                                     1'($urandom), !likely()));
                pending_items.push_back(make_control(sdsm_pkg::CMD_SHUTDOWN, 1'($urandom),
                                                     1'($urandom), 1'($urandom)));
                pending_items.push_back(make_control(sdsm_pkg::CMD_SWITCH_ON, 1'($urandom),
                                                     1'($urandom), 1'($urandom)));
                pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, likely(),
                                                     likely(), 1'($urandom)));
                n += 4;
            end
            else
            begin
                pending_items.push_back(make_control(3'($urandom_range(0, 6)), likely(),
                                                     likely(), 1'($urandom)));
                n++;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(predict_drive(item_in));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    item_in <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sdsm_pkg::sdsm_out_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding: %h", result_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status_word", want.status_word, result_out.status_word);
                    compare_field("power_state", 16'(want.power_state),
                                  16'(result_out.power_state));
                    compare_field("state_changed", 16'(want.state_changed),
                                  16'(result_out.state_changed));
                    compare_field("command_code", 16'(want.command_code),
                                  16'(result_out.command_code));
                    compare_field("warning_code", 16'(want.warning_code),
                                  16'(result_out.warning_code));
                    compare_field("clear_power_ready", 16'(want.clear_power_ready),
                                  16'(result_out.clear_power_ready));
                    compare_field("clear_clutch_manual", 16'(want.clear_clutch_manual),
                                  16'(result_out.clear_clutch_manual));
                    compare_field("reset_filters_pulse", 16'(want.reset_filters_pulse),
                                  16'(result_out.reset_filters_pulse));
                    compare_field("init_mode_pulse", 16'(want.init_mode_pulse),
                                  16'(result_out.init_mode_pulse));
                end
            end
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("servo_drive_state_machine_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        sdsm_pkg::sdsm_in_t it;
        sender_idle_pct = 12;
        receiver_stall_pct = 83;

        // field extremes and warnings from not ready
        it = make_control(sdsm_pkg::CMD_DISABLE_V, 1'b0, 1'b0, 1'b0);
        it.control_word = 16'h0000;
        it.forced_state = 4'h0;
        pending_items.push_back(it);
        it = make_control(sdsm_pkg::CMD_FRESET, 1'b1, 1'b1, 1'b1);
        it.control_word = 16'hFFFF;
        it.forced_state = 4'hF;
        pending_items.push_back(it);
        pending_items.push_back(make_control(sdsm_pkg::CMD_HALT, 1'b1, 1'b1, 1'b0));

        // forcing codes that write nothing
        pending_items.push_back(make_force(sdsm_pkg::ST_ERROR));
        pending_items.push_back(make_force(sdsm_pkg::ST_START));
        pending_items.push_back(make_force(ST_UNUSED_TOP));
        pending_items.push_back(make_force(ST_UNUSED_LOW));

        // normal power-up with already-in-target and refused enables
        pending_items.push_back(make_force(sdsm_pkg::ST_SOD));
        pending_items.push_back(make_control(sdsm_pkg::CMD_DISABLE_V, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SHUTDOWN, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SHUTDOWN, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SWITCH_ON, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, 1'b0, 1'b0, 1'b1));
        pending_items.push_back(make_control(sdsm_pkg::CMD_HALT, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SWITCH_ON, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_ENABLE, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_QSTOP, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_QSTOP, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_DISABLE_V, 1'b1, 1'b1, 1'b0));

        // fault reaction and fault reset, blocked then allowed
        pending_items.push_back(make_force(sdsm_pkg::ST_FRA));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SHUTDOWN, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_control(sdsm_pkg::CMD_SWITCH_ON, 1'b1, 1'b1, 1'b0));
        pending_items.push_back(make_force(sdsm_pkg::ST_FLT));
        pending_items.push_back(make_control(sdsm_pkg::CMD_FRESET, 1'b1, 1'b1, 1'b1));
        pending_items.push_back(make_control(sdsm_pkg::CMD_FRESET, 1'b1, 1'b1, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_random(280);
        wait_idle();

        sender_idle_pct = 83;
        receiver_stall_pct = 12;
        queue_random(300);
        wait_idle();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_random(300);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("servo_drive_state_machine_unit: match");
        else
            $display("servo_drive_state_machine_unit: mismatch");
        $finish;
    end

endmodule
